// File: src/block_average_downsample_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the block average downsampler
// Concurrent assertion wrappers. Define ASSERT_OFF to compile them away.
// ----------------------------------------------------------------------------
`ifndef BLOCK_AVERAGE_DOWNSAMPLE_UNIT_MACROS_SVH
`define BLOCK_AVERAGE_DOWNSAMPLE_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// Check a property on every rising clock edge outside reset
`define BADS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that a condition implies a consequence in the same cycle
`define BADS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define BADS_ASSERT(lbl, clk, rst_n, prop, msg)
`define BADS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: src/bads_pkg.sv
// ----------------------------------------------------------------------------
// Block average downsampler package
// Shared widths, defaults and configuration register indexes.
// ----------------------------------------------------------------------------
package bads_pkg;

  // Default parameter values
  localparam int MAX_COLS_DEF   = 4096;
  localparam int MAX_BLOCK_DEF  = 16;
  localparam int PIXEL_BITS_DEF = 24;

  // Fixed widths
  localparam int SUM_W     = 32;
  localparam int COORD_W   = 12;
  localparam int CFG_DIM_W = 13;
  localparam int CFG_BS_W  = 5;
  localparam int CFG_IDX_W = 2;
  localparam int STEP_W    = $clog2(SUM_W + 1);

  // Register reset values
  localparam logic [CFG_DIM_W-1:0] COLS_RST = 13'd640;
  localparam logic [CFG_DIM_W-1:0] ROWS_RST = 13'd480;
  localparam logic [CFG_BS_W-1:0]  BS_RST   = 5'd2;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_COLS = 2'd0,
    CFG_FRAME_ROWS = 2'd1,
    CFG_BLOCK_SIZE = 2'd2
  } cfg_idx_e;

endpackage

// File: src/bads_div.sv
// ----------------------------------------------------------------------------
// Shared restoring divider
// Unsigned division, one quotient bit per cycle. The dividend is left
// aligned by the caller; steps sets how many top bits are consumed.
// ----------------------------------------------------------------------------
module bads_div #(
  parameter int DVS_W = 9
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [bads_pkg::SUM_W-1:0]  dividend_i,
  input  logic [DVS_W-1:0]          divisor_i,
  input  logic [bads_pkg::STEP_W-1:0] steps_i,
  output logic                      busy_o,
  output logic                      done_o,
  output logic [bads_pkg::SUM_W-1:0]  quot_o,
  output logic [DVS_W-1:0]          rem_o
);
  import bads_pkg::*;

  logic              busy_q, done_q;
  logic [STEP_W-1:0] cnt_q;
  logic [SUM_W-1:0]  quot_q;
  logic [DVS_W-1:0]  rem_q, divisor_q;
  logic [DVS_W:0]    rem_sh, rem_sub;
  logic              fits;
  logic [DVS_W-1:0]  rem_nx;

  // Shift in the next dividend bit and try a subtract
  always_comb begin
    rem_sh  = {rem_q, quot_q[SUM_W-1]};
    rem_sub = rem_sh - {1'b0, divisor_q};
    fits    = rem_sh >= {1'b0, divisor_q};
    rem_nx  = fits ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
  end

  // Control: step count and done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= steps_i;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: load operands, then advance one bit a cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q    <= dividend_i;
      rem_q     <= '0;
      divisor_q <= divisor_i;
    end else if (busy_q) begin
      quot_q <= {quot_q[SUM_W-2:0], fits};
      rem_q  <= rem_nx;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

// File: src/bads_colmem.sv
// ----------------------------------------------------------------------------
// Column sum memory
// One accumulator per coarse column; one write and one registered read port.
// ----------------------------------------------------------------------------
module bads_colmem #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic [AW-1:0]            rd_addr_i,
  output logic [bads_pkg::SUM_W-1:0] rd_data_o,
  input  logic                     wr_en_i,
  input  logic [AW-1:0]            wr_addr_i,
  input  logic [bads_pkg::SUM_W-1:0] wr_data_i
);
  import bads_pkg::*;

  logic [SUM_W-1:0] mem_q [DEPTH];
  logic [SUM_W-1:0] rd_data_q;

  // Write accumulator
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: src/block_average_downsample_unit.sv
// ----------------------------------------------------------------------------
// Block average downsampler
// Box filter: averages square tiles of a raster pixel stream into one pixel.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / pixel_i) takes fine pixels in
//   raster order. Output channel (out_valid_o / out_stall_i) delivers one
//   coarse pixel with its row, column and frame_done flag per whole tile.
//   Config channel (cfg_valid_i / cfg_ready_o) writes frame_cols (index 0),
//   frame_rows (1) and block_size (2); it is always ready. Write only when
//   the block is idle.
//   Timing: all index and average work runs through one shared bit-serial
//   divider. A pixel that closes no tile goes through the column and row
//   index divisions, the column sum read and the sum update; a pixel that
//   closes a tile then also divides the tile sum by block_size squared and
//   the frame rows and columns by block_size, and its result shows in the
//   cycle in which in_stall_o falls. in_stall_o is high while a pixel is in work.
//   The output register holds one result; a new pixel is taken while it
//   waits, and the next result waits until the register is taken.
//   Reset returns the position to row 0, column 0 and the registers to
//   640, 480, 2. The column sums are not cleared.
// ----------------------------------------------------------------------------
`include "block_average_downsample_unit_macros.svh"

module block_average_downsample_unit #(
  parameter int MAX_COLS   = bads_pkg::MAX_COLS_DEF,
  parameter int MAX_BLOCK  = bads_pkg::MAX_BLOCK_DEF,
  parameter int PIXEL_BITS = bads_pkg::PIXEL_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Pixel input
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic signed [PIXEL_BITS-1:0]     pixel_i,
  // Coarse pixel output
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [PIXEL_BITS-1:0]     average_o,
  output logic [bads_pkg::COORD_W-1:0]     coarse_row_o,
  output logic [bads_pkg::COORD_W-1:0]     coarse_col_o,
  output logic                             frame_done_o,
  // Configuration write
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [bads_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [bads_pkg::CFG_DIM_W-1:0]   cfg_data_i
);
  import bads_pkg::*;

  localparam int POS_W  = $clog2(MAX_COLS);
  localparam int DIM_W  = $clog2(MAX_COLS + 1);
  localparam int DIMP_W = DIM_W + 1;
  localparam int BS_W   = $clog2(MAX_BLOCK + 1);
  localparam int DVS_W  = $clog2(MAX_BLOCK * MAX_BLOCK + 1);
  localparam int PAD_W  = SUM_W - DIM_W;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_DCOL  = 9'b000000010,
    S_DROW  = 9'b000000100,
    S_RD    = 9'b000001000,
    S_UPD   = 9'b000010000,
    S_DAVG  = 9'b000100000,
    S_DRCNT = 9'b001000000,
    S_DCCNT = 9'b010000000,
    S_EMIT  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers
  logic [CFG_DIM_W-1:0] cols_cfg_q, rows_cfg_q;
  logic [CFG_BS_W-1:0]  bs_cfg_q;
  logic [DIM_W-1:0]     cols_eff, rows_eff;
  logic [BS_W-1:0]      bs_eff;
  logic [DVS_W-1:0]     bs_div, bs_sq;

  // Position and per-item registers
  logic [POS_W-1:0]            row_pos_q, col_pos_q;
  logic signed [PIXEL_BITS-1:0] pixel_q;
  logic [POS_W-1:0]            tc_q, rt_q;
  logic [BS_W-1:0]             cm_q, rm_q;
  logic [SUM_W-1:0]            sum_q;
  logic [PIXEL_BITS-1:0]       avg_q;
  logic [DIM_W-1:0]            rows_t_q, cols_t_q;

  // Output register
  logic                        out_valid_q;
  logic [PIXEL_BITS-1:0]       average_q;
  logic [COORD_W-1:0]          coarse_row_q, coarse_col_q;
  logic                        frame_done_q;

  // Divider and memory hookup
  logic                        div_start, div_busy, div_done;
  logic [SUM_W-1:0]            div_dividend, div_quot;
  logic [DVS_W-1:0]            div_divisor, div_rem;
  logic [STEP_W-1:0]           div_steps;
  logic [SUM_W-1:0]            mem_rdata;

  logic                        in_acc, out_load, cfg_acc;
  logic [SUM_W-1:0]            px_ext, sum_new, sum_mag, quot_signed;
  logic                        tile_start, tile_end;
  logic [DIMP_W-1:0]           col_inc, row_inc;
  logic                        frame_last;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign cfg_acc    = cfg_valid_i && cfg_ready_o;
  assign out_load   = (state_q == S_EMIT) && (!out_valid_q || !out_stall_i);

  // Clamp the register values to their working ranges
  always_comb begin
    if (cols_cfg_q == '0) begin
      cols_eff = DIM_W'(1);
    end else if (32'(cols_cfg_q) > 32'(MAX_COLS)) begin
      cols_eff = DIM_W'(MAX_COLS);
    end else begin
      cols_eff = DIM_W'(cols_cfg_q);
    end
    if (rows_cfg_q == '0) begin
      rows_eff = DIM_W'(1);
    end else if (32'(rows_cfg_q) > 32'(MAX_COLS)) begin
      rows_eff = DIM_W'(MAX_COLS);
    end else begin
      rows_eff = DIM_W'(rows_cfg_q);
    end
    if (bs_cfg_q == '0) begin
      bs_eff = BS_W'(1);
    end else if (32'(bs_cfg_q) > 32'(MAX_BLOCK)) begin
      bs_eff = BS_W'(MAX_BLOCK);
    end else begin
      bs_eff = BS_W'(bs_cfg_q);
    end
    bs_div = DVS_W'(bs_eff);
    bs_sq  = DVS_W'(bs_eff) * DVS_W'(bs_eff);
  end

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_cfg_q <= COLS_RST;
      rows_cfg_q <= ROWS_RST;
      bs_cfg_q   <= BS_RST;
    end else if (cfg_acc) begin
      case (cfg_index_i)
        CFG_FRAME_COLS: cols_cfg_q <= cfg_data_i;
        CFG_FRAME_ROWS: rows_cfg_q <= cfg_data_i;
        CFG_BLOCK_SIZE: bs_cfg_q   <= cfg_data_i[CFG_BS_W-1:0];
        default: ;
      endcase
    end
  end

  // Tile arithmetic for the update step
  always_comb begin
    px_ext      = SUM_W'(pixel_q);
    tile_start  = (rm_q == '0) && (cm_q == '0);
    sum_new     = tile_start ? px_ext : mem_rdata + px_ext;
    sum_mag     = sum_new[SUM_W-1] ? (~sum_new + 1'b1) : sum_new;
    tile_end    = (rm_q == BS_W'(bs_eff - 1'b1)) && (cm_q == BS_W'(bs_eff - 1'b1)) &&
                  (DIM_W'(row_pos_q) < rows_eff) && (DIM_W'(col_pos_q) < cols_eff);
    col_inc     = DIMP_W'(col_pos_q) + 1'b1;
    row_inc     = DIMP_W'(row_pos_q) + 1'b1;
    quot_signed = sum_q[SUM_W-1] ? (~div_quot + 1'b1) : div_quot;
    frame_last  = (DIMP_W'(rt_q) + 1'b1 == DIMP_W'(rows_t_q)) &&
                  (DIMP_W'(tc_q) + 1'b1 == DIMP_W'(cols_t_q));
  end

  // Sequencer: issue divider requests and step through the item
  always_comb begin
    state_d      = state_q;
    div_start    = 1'b0;
    div_dividend = {DIM_W'(col_pos_q), {PAD_W{1'b0}}};
    div_divisor  = bs_div;
    div_steps    = STEP_W'(DIM_W);
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          div_start = 1'b1;
          state_d   = S_DCOL;
        end
      end
      S_DCOL: begin
        if (div_done) begin
          div_start    = 1'b1;
          div_dividend = {DIM_W'(row_pos_q), {PAD_W{1'b0}}};
          state_d      = S_DROW;
        end
      end
      S_DROW: begin
        if (div_done) begin
          state_d = S_RD;
        end
      end
      S_RD: begin
        state_d = S_UPD;
      end
      S_UPD: begin
        if (tile_end) begin
          div_start    = 1'b1;
          div_dividend = sum_mag;
          div_divisor  = bs_sq;
          div_steps    = STEP_W'(SUM_W);
          state_d      = S_DAVG;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_DAVG: begin
        if (div_done) begin
          div_start    = 1'b1;
          div_dividend = {rows_eff, {PAD_W{1'b0}}};
          state_d      = S_DRCNT;
        end
      end
      S_DRCNT: begin
        if (div_done) begin
          div_start    = 1'b1;
          div_dividend = {cols_eff, {PAD_W{1'b0}}};
          state_d      = S_DCCNT;
        end
      end
      S_DCCNT: begin
        if (div_done) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers: state, position, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      row_pos_q   <= '0;
      col_pos_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      // Advance the raster position once the pixel is accumulated
      if (state_q == S_UPD) begin
        if (col_inc >= DIMP_W'(cols_eff)) begin
          col_pos_q <= '0;
          row_pos_q <= (row_inc >= DIMP_W'(rows_eff)) ? '0 : POS_W'(row_inc);
        end else begin
          col_pos_q <= POS_W'(col_inc);
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: capture divider results and the tile sum
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pixel_q <= pixel_i;
    end
    if (state_q == S_DCOL && div_done) begin
      tc_q <= div_quot[POS_W-1:0];
      cm_q <= div_rem[BS_W-1:0];
    end
    if (state_q == S_DROW && div_done) begin
      rt_q <= div_quot[POS_W-1:0];
      rm_q <= div_rem[BS_W-1:0];
    end
    if (state_q == S_UPD) begin
      sum_q <= sum_new;
    end
    if (state_q == S_DAVG && div_done) begin
      avg_q <= quot_signed[PIXEL_BITS-1:0];
    end
    if (state_q == S_DRCNT && div_done) begin
      rows_t_q <= div_quot[DIM_W-1:0];
    end
    if (state_q == S_DCCNT && div_done) begin
      cols_t_q <= div_quot[DIM_W-1:0];
    end
    if (out_load) begin
      average_q    <= avg_q;
      coarse_row_q <= COORD_W'(rt_q);
      coarse_col_q <= COORD_W'(tc_q);
      frame_done_q <= frame_last;
    end
  end

  bads_div #(
    .DVS_W (DVS_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .steps_i    (div_steps),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  bads_colmem #(
    .DEPTH (MAX_COLS),
    .AW    (POS_W)
  ) u_colmem (
    .clk_i     (clk_i),
    .rd_en_i   (state_q == S_RD),
    .rd_addr_i (tc_q),
    .rd_data_o (mem_rdata),
    .wr_en_i   (state_q == S_UPD),
    .wr_addr_i (tc_q),
    .wr_data_i (sum_new)
  );

  assign out_valid_o  = out_valid_q;
  assign average_o    = average_q;
  assign coarse_row_o = coarse_row_q;
  assign coarse_col_o = coarse_col_q;
  assign frame_done_o = frame_done_q;

  // Divider requests only go to an idle divider
  `BADS_ASSERT_IMP(a_div_start_idle, clk_i, rst_ni, div_start, !div_busy, "divider restarted while busy")
  // An accepted pixel starts the column index division
  `BADS_ASSERT(a_acc_starts_div, clk_i, rst_ni, in_acc |=> div_busy, "accepted pixel did not start divider")
  // A result never overwrites one that the receiver has not taken
  `BADS_ASSERT_IMP(a_out_no_overwrite, clk_i, rst_ni, out_load, !out_valid_q || !out_stall_i, "result overwritten")
  // An emitted coarse column lies inside the coarse frame
  `BADS_ASSERT_IMP(a_col_in_frame, clk_i, rst_ni, out_load, DIM_W'(tc_q) < cols_t_q, "coarse column outside frame")

endmodule
